### design/sbm_pkg.sv
// Shared types, register indexes and status codes of the send backlog monitor.
package sbm_pkg;

  // Default geometry
  localparam int unsigned DEF_HISTORY_DEPTH = 12;
  localparam int unsigned DEF_SLOW_WINDOW   = 3;
  localparam int unsigned DEF_CHECK_PERIOD  = 5;

  // Field widths
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BACKLOG_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_MIN      = 1'd1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CLOSE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ACCUM = 2'd3;

  // Per-cell comparison results
  typedef struct packed {
    logic slow;   // sample sent at most the slow threshold
    logic rise;   // queue did not shrink against the next older sample
  } cell_flags_t;

  // Row-level verdicts for the controller
  typedef struct packed {
    logic window_slow;  // every sample in the slow window is slow
    logic all_rising;   // queue never shrank across the whole row
  } hist_flags_t;

endpackage

### design/sbm_item_if.sv
// Handshake channel carrying one send-attempt item.
interface sbm_item_if
  import sbm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sent_bytes;
  logic [DATA_W-1:0] queue_before;
  logic [DATA_W-1:0] queue_after;
  logic [DATA_W-1:0] now_seconds;
  logic              close_requested;

  modport source (
    output valid, sent_bytes, queue_before, queue_after, now_seconds, close_requested,
    input  ready
  );
  modport sink (
    input  valid, sent_bytes, queue_before, queue_after, now_seconds, close_requested,
    output ready
  );
endinterface

### design/sbm_result_if.sv
// Handshake channel carrying one status result.
interface sbm_result_if
  import sbm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, status,
    input  ready
  );
  modport sink (
    input  valid, status,
    output ready
  );
endinterface

### design/send_backlog_monitor_core.sv
// Top level of the send backlog monitor: control, period tracking, history row.
//
//   channel   | dir | handshake            | payload
//   ----------+-----+----------------------+------------------------------------------
//   items     | in  | valid/ready          | sent_bytes, queue_before, queue_after,
//             |     |                      | now_seconds, close_requested
//   results   | out | valid/ready          | status
//   config    | in  | wr_en (no wait)      | wr_index, wr_data
//
// An item runs through update and done, plus evaluation and decision when a sample
// is pushed: the push shifts the cell row, evaluation registers the cell flags and
// decision combines them. The result sits in an output register, so the next item
// is taken while it waits; a stalled result holds the controller in its last state.
// rst is synchronous and clears the controller, registers and history count.
module send_backlog_monitor_core
  import sbm_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int unsigned SLOW_WINDOW   = DEF_SLOW_WINDOW,
  parameter int unsigned CHECK_PERIOD  = DEF_CHECK_PERIOD
) (
  input  logic                 clk,
  input  logic                 rst,
  sbm_item_if.sink             items,
  sbm_result_if.source         results,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [DATA_W-1:0]    wr_data
);

  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0] CNT_WINDOW = CNT_W'(SLOW_WINDOW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          state;
  logic [2:0]          state_next;

  logic [DATA_W-1:0]   sent_r;
  logic [DATA_W-1:0]   qbefore_r;
  logic [DATA_W-1:0]   qafter_r;
  logic [DATA_W-1:0]   now_r;
  logic                close_r;

  logic [DATA_W-1:0]   backlog_limit;
  logic [DATA_W-1:0]   slow_min_bytes;
  logic [DATA_W-1:0]   period_bytes;
  logic [DATA_W-1:0]   last_check_time;
  logic [CNT_W-1:0]    hist_count;
  logic [STATUS_W-1:0] status_r;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;

  logic                close_hit;
  logic                backlog;
  logic [DATA_W-1:0]   check_base;
  logic [DATA_W:0]     byte_sum;
  logic [DATA_W-1:0]   pb_sat;
  logic [DATA_W-1:0]   elapsed;
  logic                period_due;
  logic                push;
  logic                out_load;
  logic                drop;
  hist_flags_t         verdict;

  // Per-item decisions in the update cycle
  assign close_hit  = close_r && (qafter_r == '0);
  assign backlog    = qafter_r > backlog_limit;
  assign check_base = (period_bytes == '0) ? now_r : last_check_time;
  assign byte_sum   = {1'b0, period_bytes} + {1'b0, sent_r};
  assign pb_sat     = byte_sum[DATA_W] ? '1 : byte_sum[DATA_W-1:0];
  assign elapsed    = now_r - check_base;
  assign period_due = (now_r >= check_base) && (elapsed >= DATA_W'(CHECK_PERIOD));
  assign push       = (state == S_UPD) && !close_hit && backlog && period_due;

  // Drop the oldest sample when the row is full, not slow, not accumulating
  assign drop = (state == S_DEC) && !(verdict.window_slow && hist_count >= CNT_WINDOW)
                && (hist_count == CNT_FULL) && !verdict.all_rising;

  assign out_load    = (state == S_DONE) && (!out_valid || results.ready);
  assign items.ready = (state == S_IDLE);

  // Sequence one item through update, evaluation and hand-off
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (items.valid) state_next = S_UPD;
      S_UPD:  state_next = push ? S_EVAL : S_DONE;
      S_EVAL: state_next = S_DEC;
      S_DEC:  state_next = S_DONE;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      sent_r    <= items.sent_bytes;
      qbefore_r <= items.queue_before;
      qafter_r  <= items.queue_after;
      now_r     <= items.now_seconds;
      close_r   <= items.close_requested;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      backlog_limit  <= '0;
      slow_min_bytes <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_BACKLOG_LIMIT: backlog_limit  <= wr_data;
        REG_SLOW_MIN:      slow_min_bytes <= wr_data;
        default: ;
      endcase
    end
  end

  // Period tracking, history count and status
  always_ff @(posedge clk) begin
    if (rst) begin
      period_bytes    <= '0;
      last_check_time <= '0;
      hist_count      <= '0;
      status_r        <= ST_OK;
    end else if (state == S_UPD) begin
      if (close_hit) begin
        status_r <= ST_CLOSE;
      end else if (backlog) begin
        status_r <= ST_OK;
        if (period_due) begin
          last_check_time <= now_r;
          period_bytes    <= '0;
          if (hist_count != CNT_FULL) begin
            hist_count <= hist_count + 1'b1;
          end
        end else begin
          last_check_time <= check_base;
          period_bytes    <= pb_sat;
        end
      end else begin
        status_r        <= ST_OK;
        period_bytes    <= '0;
        last_check_time <= now_r;
        hist_count      <= '0;
      end
    end else if (state == S_DEC) begin
      if (verdict.window_slow && hist_count >= CNT_WINDOW) begin
        status_r <= ST_SLOW;
      end else if (hist_count == CNT_FULL && verdict.all_rising) begin
        status_r <= ST_ACCUM;
      end else begin
        status_r <= ST_OK;
      end
      if (drop) begin
        hist_count <= hist_count - 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= status_r;
    end
  end

  assign results.valid  = out_valid;
  assign results.status = out_status;

  // History row
  sbm_history #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SLOW_WINDOW   (SLOW_WINDOW)
  ) u_history (
    .clk       (clk),
    .push      (push),
    .new_sent  (pb_sat),
    .new_queue (qbefore_r),
    .slow_min  (slow_min_bytes),
    .verdict   (verdict)
  );

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    hist_count <= CNT_FULL)
    else $error("history count beyond depth");

  a_clear_on_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) && !close_hit && !backlog |=> hist_count == '0)
    else $error("history not cleared without backlog");

  a_drop_oldest: assert property (@(posedge clk) disable iff (rst)
    drop |=> hist_count == CNT_FULL - 1'b1)
    else $error("oldest sample not dropped");

  a_push_path: assert property (@(posedge clk) disable iff (rst)
    push |=> state == S_EVAL ##1 state == S_DEC)
    else $error("push not followed by evaluation");

endmodule

### design/sbm_cell.sv
// One history cell: holds a sample, shifts it to the older neighbor, flags it.
module sbm_cell
  import sbm_pkg::*;
(
  input  logic              clk,
  input  logic              shift_en,
  input  logic [DATA_W-1:0] sent_in,
  input  logic [DATA_W-1:0] queue_in,
  input  logic [DATA_W-1:0] queue_older,
  input  logic [DATA_W-1:0] slow_min,
  output logic [DATA_W-1:0] sent,
  output logic [DATA_W-1:0] queue,
  output cell_flags_t       flags
);

  // Take the newer neighbor's sample on a push
  always_ff @(posedge clk) begin
    if (shift_en) begin
      sent  <= sent_in;
      queue <= queue_in;
    end
  end

  // Register the local comparisons every cycle
  always_ff @(posedge clk) begin
    flags.slow <= (sent <= slow_min);
    flags.rise <= (queue >= queue_older);
  end

endmodule

### design/sbm_history.sv
// Row of history cells, newest sample in cell 0, with the row verdicts.
module sbm_history
  import sbm_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int unsigned SLOW_WINDOW   = DEF_SLOW_WINDOW
) (
  input  logic              clk,
  input  logic              push,
  input  logic [DATA_W-1:0] new_sent,
  input  logic [DATA_W-1:0] new_queue,
  input  logic [DATA_W-1:0] slow_min,
  output hist_flags_t       verdict
);

  logic [DATA_W-1:0] sent_w  [HISTORY_DEPTH];
  logic [DATA_W-1:0] queue_w [HISTORY_DEPTH];
  cell_flags_t       flags_w [HISTORY_DEPTH];

  // Build the row; each cell feeds its older neighbor
  for (genvar j = 0; j < HISTORY_DEPTH; j++) begin : g_cell
    logic [DATA_W-1:0] sent_src;
    logic [DATA_W-1:0] queue_src;
    logic [DATA_W-1:0] queue_cmp;

    if (j == 0) begin : g_head
      assign sent_src  = new_sent;
      assign queue_src = new_queue;
    end else begin : g_body
      assign sent_src  = sent_w[j-1];
      assign queue_src = queue_w[j-1];
    end

    if (j == HISTORY_DEPTH - 1) begin : g_tail
      assign queue_cmp = queue_w[j];
    end else begin : g_link
      assign queue_cmp = queue_w[j+1];
    end

    sbm_cell u_cell (
      .clk         (clk),
      .shift_en    (push),
      .sent_in     (sent_src),
      .queue_in    (queue_src),
      .queue_older (queue_cmp),
      .slow_min    (slow_min),
      .sent        (sent_w[j]),
      .queue       (queue_w[j]),
      .flags       (flags_w[j])
    );
  end

  // Combine the registered cell flags
  always_comb begin
    verdict.window_slow = 1'b1;
    verdict.all_rising  = 1'b1;
    for (int k = 0; k < SLOW_WINDOW; k++) begin
      verdict.window_slow = verdict.window_slow & flags_w[k].slow;
    end
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      verdict.all_rising = verdict.all_rising & flags_w[k].rise;
    end
  end

endmodule
